// ===== rtl/sdpfe_pkg.sv =====
`timescale 1ns / 1ps

package sdpfe_pkg;

    localparam int WORD_W = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 6;

    // Item kinds.
    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_ENCODE = 2'd1;
    localparam logic [1:0] KIND_IMMEDIATE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_START = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIR_START = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_WIDTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_SHIFT = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [5:0] FRAME_LENGTH_RST = 6'd32;
    localparam logic [4:0] STEP_START_RST = 5'd2;
    localparam logic [4:0] DIR_START_RST = 5'd1;
    localparam logic [4:0] MIN_WIDTH_RST = 5'd2;
    localparam logic [4:0] GAP_RST = 5'd2;
    localparam logic [1:0] RATE_SHIFT_RST = 2'd0;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] sig_id;
        logic       direction;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] step_word;
        logic [WORD_W-1:0] dir_word;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_IMM
    } state_t;

    typedef struct packed {
        logic add;
        logic walk_init;
        logic imm_init;
        logic walk_step;
        logic imm_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic walk_last;
        logic fits;
    } ctrl_status_t;

    // Pulse of width_slots slots at slot pos_slots, scaled to bits and clipped to the word.
    function automatic logic [WORD_W-1:0] place_pulse(
        input logic [6:0] width_slots,
        input logic [7:0] pos_slots,
        input logic [1:0] shift
    );
        logic [9:0]        width_bits;
        logic [10:0]       pos_bits;
        logic [WORD_W-1:0] mask;
        width_bits = {3'b000, width_slots} << shift;
        pos_bits = {3'b000, pos_slots} << shift;
        if (width_bits >= 10'd32)
        begin
            mask = '1;
        end
        else
        begin
            mask = (32'h1 << width_bits[4:0]) - 32'h1;
        end
        if (pos_bits >= 11'd32)
        begin
            place_pulse = '0;
        end
        else
        begin
            place_pulse = mask << pos_bits[4:0];
        end
    endfunction

endpackage

// ===== rtl/sdpfe_datapath.sv =====
`timescale 1ns / 1ps

module sdpfe_datapath #(
    parameter int SIGNAL_COUNT = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sdpfe_pkg::in_item_t               item,
    input  sdpfe_pkg::ctrl_cmd_t              cmd,
    output sdpfe_pkg::ctrl_status_t           status,
    input  logic                              cfg_we,
    input  logic [sdpfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sdpfe_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sdpfe_pkg::out_item_t              result,
    output logic                              result_valid
);
    import sdpfe_pkg::*;

    localparam int IDX_W = (SIGNAL_COUNT > 1) ? $clog2(SIGNAL_COUNT) : 1;

    logic [5:0] frame_length_reg;
    logic [4:0] step_start_reg;
    logic [4:0] dir_start_reg;
    logic [4:0] min_width_reg;
    logic [4:0] gap_reg;
    logic [1:0] rate_shift_reg;

    logic [SIGNAL_COUNT-1:0] active_reg;
    logic [SIGNAL_COUNT-1:0] forward_reg;

    logic [IDX_W-1:0]  cnt_reg;
    logic              stop_reg;
    logic [7:0]        step_pos_reg;
    logic [7:0]        dir_pos_reg;
    logic [WORD_W-1:0] step_acc_reg;
    logic [WORD_W-1:0] dir_acc_reg;
    logic [3:0]        imm_index_reg;
    logic              imm_dir_reg;
    out_item_t         result_reg;
    logic              valid_reg;

    logic [5:0]        idx_ext;
    logic              idx_in_range;
    logic [4:0]        w_base;
    logic [7:0]        pos_s;
    logic [7:0]        pos_d;
    logic              use_sig;
    logic              fwd_sig;
    logic [6:0]        step_w;
    logic [6:0]        dir_w;
    logic              fits;
    logic              place;
    logic [WORD_W-1:0] step_hit;
    logic [WORD_W-1:0] dir_hit;
    logic [WORD_W-1:0] step_acc_next;
    logic [WORD_W-1:0] dir_acc_next;

    assign idx_ext = {2'b00, item.sig_id};
    assign idx_in_range = idx_ext < 6'(SIGNAL_COUNT);

    // The same pulse unit serves one walk step or the immediate frame.
    always_comb
    begin
        if (cmd.imm_step)
        begin
            w_base = {1'b0, imm_index_reg};
            pos_s = {3'b000, step_start_reg};
            pos_d = {3'b000, dir_start_reg};
            use_sig = 1'b1;
            fwd_sig = imm_dir_reg;
        end
        else
        begin
            w_base = 5'(cnt_reg);
            pos_s = step_pos_reg;
            pos_d = dir_pos_reg;
            use_sig = active_reg[cnt_reg] & ~stop_reg;
            fwd_sig = forward_reg[cnt_reg];
        end
        step_w = {2'b00, w_base} + {2'b00, min_width_reg};
        dir_w = step_w + {2'b00, gap_reg};
        fits = ({1'b0, pos_s} + {2'b00, step_w}) < {3'b000, frame_length_reg};
        place = use_sig & fits;
        step_hit = place ? place_pulse(step_w, pos_s, rate_shift_reg) : '0;
        dir_hit = (place & fwd_sig) ? place_pulse(dir_w, pos_d, rate_shift_reg) : '0;
        step_acc_next = step_acc_reg | step_hit;
        dir_acc_next = dir_acc_reg | dir_hit;
    end

    assign status.walk_last = cnt_reg == IDX_W'(SIGNAL_COUNT - 1);
    assign status.fits = fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= FRAME_LENGTH_RST;
            step_start_reg <= STEP_START_RST;
            dir_start_reg <= DIR_START_RST;
            min_width_reg <= MIN_WIDTH_RST;
            gap_reg <= GAP_RST;
            rate_shift_reg <= RATE_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_LENGTH: frame_length_reg <= cfg_data;
                CFG_STEP_START:   step_start_reg <= cfg_data[4:0];
                CFG_DIR_START:    dir_start_reg <= cfg_data[4:0];
                CFG_MIN_WIDTH:    min_width_reg <= cfg_data[4:0];
                CFG_GAP:          gap_reg <= cfg_data[4:0];
                CFG_RATE_SHIFT:   rate_shift_reg <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            valid_reg <= 1'b0;
            cnt_reg <= '0;
            stop_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            if (cmd.add && idx_in_range)
            begin
                active_reg[idx_ext[IDX_W-1:0]] <= 1'b1;
            end
            if (cmd.walk_step && cmd.emit)
            begin
                active_reg <= '0;
            end
            if (cmd.walk_init)
            begin
                cnt_reg <= '0;
                stop_reg <= 1'b0;
            end
            else if (cmd.walk_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                // The first pulse that does not fit ends the walk.
                if (use_sig && !fits)
                begin
                    stop_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add && idx_in_range)
        begin
            forward_reg[idx_ext[IDX_W-1:0]] <= item.direction;
        end
        if (cmd.walk_init || cmd.imm_init)
        begin
            step_acc_reg <= '0;
            dir_acc_reg <= '0;
            step_pos_reg <= {3'b000, step_start_reg};
            dir_pos_reg <= {3'b000, dir_start_reg};
            imm_index_reg <= item.sig_id;
            imm_dir_reg <= item.direction;
        end
        else if (cmd.walk_step && place)
        begin
            step_acc_reg <= step_acc_next;
            dir_acc_reg <= dir_acc_next;
            step_pos_reg <= step_pos_reg + {1'b0, step_w} + {3'b000, gap_reg};
            dir_pos_reg <= dir_pos_reg + {1'b0, dir_w};
        end
        if (cmd.emit)
        begin
            result_reg.step_word <= step_acc_next;
            result_reg.dir_word <= dir_acc_next;
        end
    end

    assign result = result_reg;
    assign result_valid = valid_reg;

`ifndef SYNTHESIS
    a_clear_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk_step && cmd.emit) |=> (active_reg == '0))
        else $error("active flags not cleared after a frame");
    a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stop_reg && cmd.walk_step && !cmd.walk_init) |=> stop_reg)
        else $error("walk resumed after an overrun");
    a_strobe_follows_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> valid_reg)
        else $error("result strobe missing after emit");
`endif

endmodule

// ===== rtl/sdpfe_controller.sv =====
`timescale 1ns / 1ps

module sdpfe_controller (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [1:0]              kind,
    input  sdpfe_pkg::ctrl_status_t status,
    output sdpfe_pkg::ctrl_cmd_t    cmd,
    output logic                    busy
);
    import sdpfe_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy = state_reg != ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind)
                        KIND_ADD:
                        begin
                            cmd.add = 1'b1;
                        end
                        KIND_ENCODE:
                        begin
                            cmd.walk_init = 1'b1;
                            state_next = ST_WALK;
                        end
                        KIND_IMMEDIATE:
                        begin
                            cmd.imm_init = 1'b1;
                            state_next = ST_IMM;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_last)
                begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_IMM:
            begin
                cmd.imm_step = 1'b1;
                cmd.emit = status.fits;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_encode_enters_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_ENCODE) |=> (state_reg == ST_WALK))
        else $error("encode item did not start a walk");
    a_imm_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IMM) |=> (state_reg == ST_IDLE))
        else $error("immediate frame took more than one cycle");
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> ((state_reg == ST_WALK && status.walk_last)
                   || (state_reg == ST_IMM && status.fits)))
        else $error("result emitted outside a frame end");
`endif

endmodule

// ===== rtl/step_dir_pulse_frame_encoder_unit.sv =====
`timescale 1ns / 1ps

// Step/direction pulse-width frame encoder.
// Input items arrive on item with start; an item is taken at a clock edge where
// start is high and busy is low. Kind add marks a signal active in that same
// cycle and gives no result; busy stays low, so adds may come every cycle.
// Kind encode walks the signal table, one signal per cycle, with one shared
// pulse unit; the frame is registered into result at the last signal and shown
// with result_valid for one cycle. The block is busy during the walk and takes
// no new item until idle. Kind immediate makes one pass through the pulse unit;
// its result, if the pulse fits the frame, is registered with result_valid.
// The result register holds the frame while the next item is taken; the
// receiver must take result_valid cycles as they come, it cannot stall.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while idle, which the block itself does not enforce.
// Reset restores the configuration defaults and clears all active flags.
module step_dir_pulse_frame_encoder_unit #(
    parameter int SIGNAL_COUNT = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  sdpfe_pkg::in_item_t               item,
    output sdpfe_pkg::out_item_t              result,
    output logic                              result_valid,
    input  logic                              cfg_we,
    input  logic [sdpfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sdpfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sdpfe_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    sdpfe_controller u_controller (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (item.kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sdpfe_datapath #(
        .SIGNAL_COUNT (SIGNAL_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
